### hw/rtl/tbp_pkg.sv
// Shared types, sizes and the saturating counter helper for the tournament branch predictor.
`default_nettype none
package tbp_pkg;

    localparam int LH_ENTRIES  = 1024;
    localparam int LC_ENTRIES  = 2048;
    localparam int G_ENTRIES   = 4096;
    localparam int CTR_BITS    = 2;
    localparam int PC_SHIFT    = 2;
    localparam int PC_BITS     = 32;

    localparam int LH_IW  = $clog2(LH_ENTRIES);
    localparam int LC_IW  = $clog2(LC_ENTRIES);
    localparam int G_IW   = $clog2(G_ENTRIES);
    localparam int MAX_AB = (LH_IW > LC_IW) ? LH_IW : LC_IW;
    localparam int CLR_IW = (MAX_AB > G_IW) ? MAX_AB : G_IW;

    localparam logic [CTR_BITS-1:0] CTR_MAX = {CTR_BITS{1'b1}};

    typedef struct packed {
        logic [PC_BITS-1:0] branch_pc;
        logic               taken;
    } t_req;

    typedef struct packed {
        logic prediction;
        logic correct;
        logic used_global;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_HIST,
        ST_RD_CTR,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic clear_en;
        logic capture;
        logic rd_hist;
        logic rd_ctr;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
    } t_status;

    function automatic logic [CTR_BITS-1:0] ctr_move(input logic [CTR_BITS-1:0] c,
                                                     input logic up);
        logic [CTR_BITS-1:0] r;
        if (up) begin
            r = (c == CTR_MAX) ? c : c + 1'b1;
        end else begin
            r = (c == '0) ? c : c - 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/tbp_ctrl.sv
// Sequencer for the predictor: clearing pass, table reads and the update step.
`default_nettype none
module tbp_ctrl
    import tbp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RD_HIST;
                end
            end
            ST_RD_HIST: n_state = ST_RD_CTR;
            ST_RD_CTR:  n_state = ST_UPDATE;
            ST_UPDATE:  n_state = ST_IDLE;
            default:    n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_CLEAR:   o_cmd.clear_en = 1'b1;
            ST_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.capture = i_start;
            end
            ST_RD_HIST: o_cmd.rd_hist = 1'b1;
            ST_RD_CTR:  o_cmd.rd_ctr  = 1'b1;
            ST_UPDATE:  o_cmd.update  = 1'b1;
            default:    o_busy        = 1'b1;
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/tbp_datapath.sv
// Predictor tables, histories, prediction logic and training write-back.
`default_nettype none
module tbp_datapath
    import tbp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire t_req i_req,
    output t_status   o_status,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    logic [LC_IW-1:0]    lh_mem [LH_ENTRIES];
    logic [CTR_BITS-1:0] lc_mem [LC_ENTRIES];
    logic [CTR_BITS-1:0] gc_mem [G_ENTRIES];
    logic [CTR_BITS-1:0] cc_mem [G_ENTRIES];

    logic [CLR_IW-1:0]   r_clr_idx;
    logic [LH_IW-1:0]    r_lh_idx;
    logic                r_taken;
    logic [LC_IW-1:0]    r_lh_q;
    logic [CTR_BITS-1:0] r_lc_q;
    logic [CTR_BITS-1:0] r_gc_q;
    logic [CTR_BITS-1:0] r_cc_q;
    logic [G_IW-1:0]     r_ghr;
    logic                r_valid;
    t_rsp                r_rsp;

    logic loc_pred;
    logic glb_pred;
    logic use_glb;
    logic final_pred;

    assign loc_pred   = r_lc_q[CTR_BITS-1];
    assign glb_pred   = r_gc_q[CTR_BITS-1];
    assign use_glb    = r_cc_q[CTR_BITS-1];
    assign final_pred = use_glb ? glb_pred : loc_pred;

    assign o_status.clear_done = (r_clr_idx == {CLR_IW{1'b1}});
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Clearing pass index and the small control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_ghr     <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cmd.clear_en) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.update) begin
                r_ghr <= {r_ghr[G_IW-2:0], r_taken};
            end
            r_valid <= i_cmd.update;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lh_idx <= i_req.branch_pc[PC_SHIFT +: LH_IW];
            r_taken  <= i_req.taken;
        end
        if (i_cmd.update) begin
            r_rsp.prediction  <= final_pred;
            r_rsp.correct     <= (final_pred == r_taken);
            r_rsp.used_global <= use_glb;
        end
    end

    // Local history memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            lh_mem[r_clr_idx[LH_IW-1:0]] <= '0;
        end else if (i_cmd.update) begin
            lh_mem[r_lh_idx] <= {r_lh_q[LC_IW-2:0], r_taken};
        end
        if (i_cmd.rd_hist) begin
            r_lh_q <= lh_mem[r_lh_idx];
        end
    end

    // Local counter memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            lc_mem[r_clr_idx[LC_IW-1:0]] <= '0;
        end else if (i_cmd.update) begin
            lc_mem[r_lh_q] <= ctr_move(r_lc_q, r_taken);
        end
        if (i_cmd.rd_ctr) begin
            r_lc_q <= lc_mem[r_lh_q];
        end
    end

    // Global counter memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            gc_mem[r_clr_idx[G_IW-1:0]] <= '0;
        end else if (i_cmd.update) begin
            gc_mem[r_ghr] <= ctr_move(r_gc_q, r_taken);
        end
        if (i_cmd.rd_ctr) begin
            r_gc_q <= gc_mem[r_ghr];
        end
    end

    // Choice counter memory; it trains only when the two sides disagree.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            cc_mem[r_clr_idx[G_IW-1:0]] <= '0;
        end else if (i_cmd.update && (loc_pred != glb_pred)) begin
            cc_mem[r_ghr] <= ctr_move(r_cc_q, glb_pred == r_taken);
        end
        if (i_cmd.rd_ctr) begin
            r_cc_q <= cc_mem[r_ghr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/tournament_branch_predictor.sv
// Top level of the tournament (local / global / choice) branch predictor.
//
//  Channel   Ports                     Direction  Handshake
//  --------  ------------------------  ---------  ------------------------------
//  request   start, busy, i_req        in         taken when start=1 and busy=0
//  result    o_valid, o_rsp            out        one-cycle strobe, cannot stall
//
// Each request goes from acceptance to the result strobe in order: the request is
// captured, the local history memory is read, the three counter memories are
// read in parallel, and the prediction is computed and written back. The local
// history read feeds the local counter address, so the two reads are serial.
// A new request is accepted in the cycle the previous result is on o_rsp, and
// not before, since busy stays high while a request is in flight.
// After reset the block runs a clearing pass over all 4096 entries of the largest
// table and holds busy high until it ends.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module tournament_branch_predictor
    import tbp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    t_cmd    cmd;
    t_status status;

    // The controller sequences the clearing pass and the per-request steps.
    tbp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // The datapath holds the tables, both histories and the result register.
    tbp_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_status (status),
        .o_valid  (o_valid),
        .o_rsp    (o_rsp)
    );

endmodule
`default_nettype wire
